@@ rtl/dpfu_pkg.sv @@
// Package for the dual-polarization feature unit: widths, mode codes and the pipeline stage type.
// Used by the interfaces, the step modules and the top level dual_pol_feature_unit.
package dpfu_pkg;

    localparam int IW       = 32;
    localparam int FB       = 16;
    localparam int LOG_FRAC = 24;
    localparam int MW       = 31;
    localparam int OW       = 48;
    localparam int NUMW     = IW + 2;
    localparam int DENW     = IW + 1;
    localparam int QW       = NUMW + FB + 1;
    localparam int QXW      = (QW > OW) ? QW : OW + 1;
    localparam int SW       = (DENW > OW) ? DENW : OW;
    localparam int PW       = $clog2(IW);
    localparam int LW       = PW + LOG_FRAC;
    localparam int PRODW    = LW + 32;
    localparam int SH       = LOG_FRAC + 30 - FB;

    localparam logic [31:0]   DB_Q30  = 32'd3232284966;
    localparam logic [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};

    localparam logic [2:0] MODE_RATIO = 3'd0;
    localparam logic [2:0] MODE_NDIFF = 3'd1;
    localparam logic [2:0] MODE_LOGDB = 3'd2;
    localparam logic [2:0] MODE_RVI   = 3'd3;
    localparam logic [2:0] MODE_SPAN  = 3'd4;

    localparam int ST_SETUP  = 1;
    localparam int DIV_FIRST = 2;
    localparam int DIV_LAST  = QW + 1;
    localparam int LOG_FIRST = 2;
    localparam int LOG_LAST  = LOG_FRAC + 1;
    localparam int ST_DIFF   = LOG_LAST + 1;
    localparam int ST_MULT   = LOG_LAST + 2;
    localparam int ST_RND    = LOG_LAST + 3;
    localparam int NS        = QW + 2;

    typedef struct packed {
        logic             valid;
        logic             ok;
        logic             neg;
        logic [2:0]       mode;
        logic             bad;
        logic [IW-1:0]    vv;
        logic [IW-1:0]    vh;
        logic [DENW-1:0]  span;
        logic [DENW-1:0]  den;
        logic [DENW-1:0]  rem;
        logic [QW-1:0]    dq;
        logic [MW-1:0]    ma;
        logic [MW-1:0]    mb;
        logic [LW-1:0]    la;
        logic [LW-1:0]    lb;
        logic             lneg;
        logic [PRODW-1:0] lval;
        logic [OW-1:0]    fval;
        logic             fok;
        logic             fclip;
    } t_stage;

endpackage

@@ rtl/dpfu_if.sv @@
// Valid/ready channel interfaces of the dual-polarization feature unit.
// Depends on dpfu_pkg for the output width.
interface dpfu_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] copol_power;
    logic [31:0] crosspol_power;
    logic        sample_bad;
    modport source (output valid, copol_power, crosspol_power, sample_bad, input ready);
    modport sink (input valid, copol_power, crosspol_power, sample_bad, output ready);
endinterface

interface dpfu_out_if;
    logic                          valid;
    logic                          ready;
    logic signed [dpfu_pkg::OW-1:0] feature_value;
    logic                          value_ok;
    logic                          clipped;
    modport source (output valid, feature_value, value_ok, clipped, input ready);
    modport sink (input valid, feature_value, value_ok, clipped, output ready);
endinterface

interface dpfu_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] feature_mode;
    modport source (output valid, feature_mode, input ready);
    modport sink (input valid, feature_mode, output ready);
endinterface

@@ rtl/dual_pol_feature_unit.sv @@
// Per-pixel dual-polarization feature: ratio, normalized difference, log ratio in dB, RVI, span.
// One pixel per cycle; the pipeline length from input transaction to result is set by the
// 51-step restoring divider (one quotient bit per stage). The 24-step log2 squaring chain
// runs alongside it. A stalled output holds the whole pipeline; a free output slot lets a
// new pixel enter in the same cycle. Depends on dpfu_pkg, the interfaces and the step modules.
module dual_pol_feature_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dpfu_cfg_if.sink   i_cfg,
    dpfu_in_if.sink    i_pix,
    dpfu_out_if.source o_feat
);
    localparam int NS = dpfu_pkg::NS;

    logic [2:0]       r_mode;
    logic             w_en;
    dpfu_pkg::t_stage r_st [0:NS];
    dpfu_pkg::t_stage n_st [0:NS];

    logic [dpfu_pkg::DENW-1:0] w_rem [1:NS];
    logic [dpfu_pkg::QW-1:0]   w_dq  [1:NS];
    logic [dpfu_pkg::MW-1:0]   w_ma  [1:NS];
    logic [dpfu_pkg::MW-1:0]   w_mb  [1:NS];
    logic                      w_ba  [1:NS];
    logic                      w_bb  [1:NS];

    function automatic logic [dpfu_pkg::PW-1:0] f_msb(input logic [dpfu_pkg::IW-1:0] x);
        logic [dpfu_pkg::PW-1:0] p;
        p = '0;
        for (int i = 0; i < dpfu_pkg::IW; i++) begin
            if (x[i]) begin
                p = dpfu_pkg::PW'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [dpfu_pkg::MW-1:0] f_norm(input logic [dpfu_pkg::IW-1:0] x,
                                                       input logic [dpfu_pkg::PW-1:0] p);
        logic [dpfu_pkg::IW+dpfu_pkg::MW-1:0] xw;
        xw = {x, dpfu_pkg::MW'(0)};
        xw = xw << (dpfu_pkg::PW'(dpfu_pkg::IW - 1) - p);
        return xw[dpfu_pkg::IW+dpfu_pkg::MW-1 -: dpfu_pkg::MW];
    endfunction

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= dpfu_pkg::MODE_RATIO;
        end else if (i_cfg.valid) begin
            r_mode <= i_cfg.feature_mode;
        end
    end

    assign w_en        = !r_st[NS].valid || o_feat.ready;
    assign i_pix.ready = w_en;

    always_comb begin
        n_st[0]       = '0;
        n_st[0].valid = i_pix.valid;
        n_st[0].vv    = dpfu_pkg::IW'(i_pix.copol_power);
        n_st[0].vh    = dpfu_pkg::IW'(i_pix.crosspol_power);
        n_st[0].bad   = i_pix.sample_bad;
        n_st[0].mode  = r_mode;
    end

    for (genvar s = 0; s <= NS; s++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[s].valid <= 1'b0;
            end else if (w_en) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    for (genvar s = 1; s <= NS; s++) begin : g_stage
        localparam int LB = (s <= dpfu_pkg::LOG_LAST && s >= dpfu_pkg::LOG_FIRST)
                            ? dpfu_pkg::LOG_LAST - s : 0;

        if (s >= dpfu_pkg::DIV_FIRST && s <= dpfu_pkg::DIV_LAST) begin : g_div
            dpfu_div_step u_div (
                .i_den (r_st[s-1].den),
                .i_rem (r_st[s-1].rem),
                .i_dq  (r_st[s-1].dq),
                .o_rem (w_rem[s]),
                .o_dq  (w_dq[s])
            );
        end else begin : g_div_hold
            assign w_rem[s] = r_st[s-1].rem;
            assign w_dq[s]  = r_st[s-1].dq;
        end

        if (s >= dpfu_pkg::LOG_FIRST && s <= dpfu_pkg::LOG_LAST) begin : g_log
            dpfu_log_step u_loga (.i_m(r_st[s-1].ma), .o_m(w_ma[s]), .o_bit(w_ba[s]));
            dpfu_log_step u_logb (.i_m(r_st[s-1].mb), .o_m(w_mb[s]), .o_bit(w_bb[s]));
        end else begin : g_log_hold
            assign w_ma[s] = r_st[s-1].ma;
            assign w_mb[s] = r_st[s-1].mb;
            assign w_ba[s] = 1'b0;
            assign w_bb[s] = 1'b0;
        end

        always_comb begin
            logic [dpfu_pkg::DENW-1:0] sum;
            logic                      ndneg;
            logic [dpfu_pkg::IW-1:0]   diffm;
            logic [dpfu_pkg::NUMW-1:0] num;
            logic [dpfu_pkg::PW-1:0]   pa;
            logic [dpfu_pkg::PW-1:0]   pb;
            logic [dpfu_pkg::PRODW:0]  rs;
            logic [dpfu_pkg::QXW-1:0]  qx;
            logic [dpfu_pkg::OW:0]     rr;
            logic [dpfu_pkg::OW-1:0]   qr;
            logic [dpfu_pkg::SW-1:0]   spanx;
            logic [dpfu_pkg::OW-1:0]   mag;
            logic                      dclip;
            logic                      clip;
            logic                      neg;

            n_st[s]     = r_st[s-1];
            n_st[s].rem = w_rem[s];
            n_st[s].dq  = w_dq[s];
            n_st[s].ma  = w_ma[s];
            n_st[s].mb  = w_mb[s];
            if (s >= dpfu_pkg::LOG_FIRST && s <= dpfu_pkg::LOG_LAST) begin
                n_st[s].la[LB] = w_ba[s];
                n_st[s].lb[LB] = w_bb[s];
            end

            sum   = {1'b0, r_st[s-1].vv} + {1'b0, r_st[s-1].vh};
            ndneg = r_st[s-1].vh > r_st[s-1].vv;
            diffm = ndneg ? r_st[s-1].vh - r_st[s-1].vv : r_st[s-1].vv - r_st[s-1].vh;
            pa    = f_msb(r_st[s-1].vv);
            pb    = f_msb(r_st[s-1].vh);
            num   = '0;

            if (s == dpfu_pkg::ST_SETUP) begin
                n_st[s].span = sum;
                n_st[s].neg  = 1'b0;
                n_st[s].den  = sum;
                case (r_st[s-1].mode)
                    dpfu_pkg::MODE_RATIO: begin
                        num            = dpfu_pkg::NUMW'(r_st[s-1].vv);
                        n_st[s].den    = dpfu_pkg::DENW'(r_st[s-1].vh);
                        n_st[s].ok     = r_st[s-1].vh != '0;
                    end
                    dpfu_pkg::MODE_NDIFF: begin
                        num            = dpfu_pkg::NUMW'(diffm);
                        n_st[s].neg    = ndneg;
                        n_st[s].ok     = sum != '0;
                    end
                    dpfu_pkg::MODE_RVI: begin
                        num            = {r_st[s-1].vv, 2'b00};
                        n_st[s].ok     = sum != '0;
                    end
                    dpfu_pkg::MODE_LOGDB: begin
                        n_st[s].ok     = (r_st[s-1].vv != '0) && (r_st[s-1].vh != '0);
                    end
                    dpfu_pkg::MODE_SPAN: begin
                        n_st[s].ok     = 1'b1;
                    end
                    default: begin
                        n_st[s].ok     = 1'b0;
                    end
                endcase
                n_st[s].ok  = n_st[s].ok && !r_st[s-1].bad;
                n_st[s].rem = '0;
                n_st[s].dq  = {num, (dpfu_pkg::FB + 1)'(0)};
                n_st[s].ma  = f_norm(r_st[s-1].vv, pa);
                n_st[s].mb  = f_norm(r_st[s-1].vh, pb);
                n_st[s].la  = {pa, dpfu_pkg::LOG_FRAC'(0)};
                n_st[s].lb  = {pb, dpfu_pkg::LOG_FRAC'(0)};
            end

            if (s == dpfu_pkg::ST_DIFF) begin
                n_st[s].lneg = r_st[s-1].lb > r_st[s-1].la;
                n_st[s].lval = dpfu_pkg::PRODW'(n_st[s].lneg ? r_st[s-1].lb - r_st[s-1].la
                                                             : r_st[s-1].la - r_st[s-1].lb);
            end

            if (s == dpfu_pkg::ST_MULT) begin
                n_st[s].lval = dpfu_pkg::PRODW'(r_st[s-1].lval[dpfu_pkg::LW-1:0])
                             * dpfu_pkg::PRODW'(dpfu_pkg::DB_Q30);
            end

            rs = {1'b0, r_st[s-1].lval} + ((dpfu_pkg::PRODW+1)'(1) << (dpfu_pkg::SH - 1));
            if (s == dpfu_pkg::ST_RND) begin
                n_st[s].lval = dpfu_pkg::PRODW'(rs >> dpfu_pkg::SH);
                n_st[s].lneg = r_st[s-1].lneg && (n_st[s].lval != '0);
            end

            qx    = dpfu_pkg::QXW'(r_st[s-1].dq);
            rr    = {1'b0, qx[dpfu_pkg::OW-1:0]} + (dpfu_pkg::OW+1)'(1);
            qr    = rr[dpfu_pkg::OW:1];
            dclip = ((qx >> dpfu_pkg::OW) != '0) || (qr > dpfu_pkg::OUT_MAX);
            spanx = dpfu_pkg::SW'(r_st[s-1].span);
            case (r_st[s-1].mode)
                dpfu_pkg::MODE_LOGDB: begin
                    mag  = r_st[s-1].lval[dpfu_pkg::OW-1:0];
                    neg  = r_st[s-1].lneg;
                    clip = 1'b0;
                end
                dpfu_pkg::MODE_SPAN: begin
                    clip = spanx > dpfu_pkg::SW'(dpfu_pkg::OUT_MAX);
                    mag  = clip ? dpfu_pkg::OUT_MAX : spanx[dpfu_pkg::OW-1:0];
                    neg  = 1'b0;
                end
                default: begin
                    clip = dclip;
                    mag  = dclip ? dpfu_pkg::OUT_MAX : qr;
                    neg  = r_st[s-1].neg;
                end
            endcase
            if (s == NS) begin
                n_st[s].fok   = r_st[s-1].ok;
                n_st[s].fclip = r_st[s-1].ok && clip;
                n_st[s].fval  = !r_st[s-1].ok ? '0 : (neg ? -mag : mag);
            end
        end
    end

    assign o_feat.valid         = r_st[NS].valid;
    assign o_feat.feature_value = r_st[NS].fval;
    assign o_feat.value_ok      = r_st[NS].fok;
    assign o_feat.clipped       = r_st[NS].fclip;

endmodule

@@ rtl/dpfu_div_step.sv @@
// One restoring division step: shifts in one dividend bit and yields one quotient bit.
// Depends on dpfu_pkg for widths.
module dpfu_div_step (
    input  logic [dpfu_pkg::DENW-1:0] i_den,
    input  logic [dpfu_pkg::DENW-1:0] i_rem,
    input  logic [dpfu_pkg::QW-1:0]   i_dq,
    output logic [dpfu_pkg::DENW-1:0] o_rem,
    output logic [dpfu_pkg::QW-1:0]   o_dq
);
    logic [dpfu_pkg::DENW:0] w_sh;
    logic [dpfu_pkg::DENW:0] w_diff;
    logic                    w_ge;

    always_comb begin
        w_sh   = {i_rem, i_dq[dpfu_pkg::QW-1]};
        w_ge   = w_sh >= {1'b0, i_den};
        w_diff = w_sh - {1'b0, i_den};
        o_rem  = w_ge ? w_diff[dpfu_pkg::DENW-1:0] : w_sh[dpfu_pkg::DENW-1:0];
        o_dq   = {i_dq[dpfu_pkg::QW-2:0], w_ge};
    end
endmodule

@@ rtl/dpfu_log_step.sv @@
// One log2 fraction step: squares the Q1.30 mantissa and renormalizes it.
// Depends on dpfu_pkg for widths.
module dpfu_log_step (
    input  logic [dpfu_pkg::MW-1:0] i_m,
    output logic [dpfu_pkg::MW-1:0] o_m,
    output logic                    o_bit
);
    logic [2*dpfu_pkg::MW-1:0] w_sq;
    logic [dpfu_pkg::MW:0]     w_t;

    always_comb begin
        w_sq  = i_m * i_m;
        w_t   = w_sq[2*dpfu_pkg::MW-1:30];
        o_bit = w_t[dpfu_pkg::MW];
        o_m   = o_bit ? w_t[dpfu_pkg::MW:1] : w_t[dpfu_pkg::MW-1:0];
    end
endmodule
